[src/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// sizes, operation codes, table entry layout and sequencer states
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int BUCKETS    = 256;
    localparam int POOL_NODES = 256;

    localparam int KEY_W  = 32;
    localparam int HDL_W  = 32;
    localparam int MODE_W = 2;

    // bucket index is the low key bits, bucket count is a power of two
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    // link: zero is null, else node index plus one
    localparam int LINK_W = $clog2(POOL_NODES + 1);

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HDL_W-1:0]  handle;
        logic [LINK_W-1:0] link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // flags from the shared entry compare unit
    typedef struct packed {
        logic key_eq;
        logic empty;
        logic link_null;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BKT_CHK,
        ST_NODE_CHK,
        ST_ALLOC
    } st_t;

endpackage

[src/chained_hash_map_insert_lookup.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_insert_lookup: key-to-handle map with overflow chains
// one slot per bucket in a bucket ram, overflow nodes from a pool ram,
// chains walked one entry per cycle through a shared compare unit
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload                       direction
//  request   start / busy     mode, lookup_key, handle_in   in
//  result    done (strobe)    handle_out, hit, status       out
//
// a request is taken at a rising edge with start high and busy low
// lookup and insert: the bucket slot is read and checked first, then each chain
//   node visited in turn, then a new pool node is linked in when one is needed;
//   one entry is read per cycle from a ram
// clear and mode three: done shows in the cycle after the request
// a new request can be taken in the cycle that shows done
// reset: bucket valid flags and pool count cleared at once, no sweep;
//   the result strobe cannot be stalled by the receiver
//
module chained_hash_map_insert_lookup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [chm_pkg::MODE_W-1:0]  mode,
    input  logic [chm_pkg::KEY_W-1:0]   lookup_key,
    input  logic [chm_pkg::HDL_W-1:0]   handle_in,
    output logic                        done,
    output logic [chm_pkg::HDL_W-1:0]   handle_out,
    output logic                        hit,
    output logic                        status
);

    // sequencer state
    chm_pkg::st_t state_reg, state_next;

    // request payload held while the walk runs
    logic [chm_pkg::KEY_W-1:0]  key_reg;
    logic [chm_pkg::HDL_W-1:0]  hin_reg;
    logic                       ins_reg;

    // bucket slot seen at the start of the walk, reused when linking a node
    chm_pkg::entry_t bkt_reg;
    logic            bkt_cap;

    // per-bucket valid flags: an invalid bucket reads as all zero
    logic [chm_pkg::BUCKETS-1:0] valid_reg;
    logic                        valid_set;
    logic                        valid_clr;

    // pool fill count, also the index of the next free node
    logic [chm_pkg::LINK_W-1:0] nodes_used_reg;
    logic                       nodes_inc;
    logic                       pool_full;

    // result registers, zero outside the done cycle
    logic                       done_reg, done_next;
    logic [chm_pkg::HDL_W-1:0]  hout_reg, hout_next;
    logic                       hit_reg, hit_next;
    logic                       status_reg, status_next;

    // ram ports
    logic                       bkt_we, bkt_re;
    logic [chm_pkg::BKT_W-1:0]  bkt_waddr, bkt_raddr;
    chm_pkg::entry_t            bkt_wdata, bkt_rdata;
    logic                       node_we, node_re;
    logic [chm_pkg::NODE_W-1:0] node_waddr, node_raddr;
    chm_pkg::entry_t            node_wdata, node_rdata;

    // compare unit input and flags
    chm_pkg::entry_t            bkt_view;
    chm_pkg::entry_t            cmp_entry;
    chm_pkg::cmp_res_t          cmp_res;
    logic [chm_pkg::BKT_W-1:0]  key_idx;
    logic [chm_pkg::LINK_W-1:0] link_dec;

    assign key_idx   = key_reg[chm_pkg::BKT_W-1:0];
    assign pool_full = (nodes_used_reg == chm_pkg::LINK_W'(chm_pkg::POOL_NODES));

    // masked bucket slot: cleared buckets read as key 0, handle 0, null link
    assign bkt_view  = valid_reg[key_idx] ? bkt_rdata : '0;

    // one compare unit serves the bucket slot and every chain node
    assign cmp_entry = (state_reg == chm_pkg::ST_NODE_CHK) ? node_rdata : bkt_view;
    assign link_dec  = cmp_entry.link - chm_pkg::LINK_W'(1);

    chm_cmp u_cmp (
        .entry (cmp_entry),
        .key   (key_reg),
        .res   (cmp_res)
    );

    chm_ram #(
        .WIDTH (chm_pkg::ENTRY_W),
        .DEPTH (chm_pkg::BUCKETS)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .re    (bkt_re),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    chm_ram #(
        .WIDTH (chm_pkg::ENTRY_W),
        .DEPTH (chm_pkg::POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chm_pkg::ST_IDLE:
            begin
                if (start && (mode == chm_pkg::MODE_LOOKUP || mode == chm_pkg::MODE_INSERT))
                begin
                    state_next = chm_pkg::ST_BKT_CHK;
                end
            end
            chm_pkg::ST_BKT_CHK:
            begin
                if (cmp_res.empty || cmp_res.key_eq)
                begin
                    state_next = chm_pkg::ST_IDLE;
                end
                else if (cmp_res.link_null)
                begin
                    state_next = (ins_reg && !pool_full) ? chm_pkg::ST_ALLOC
                                                         : chm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = chm_pkg::ST_NODE_CHK;
                end
            end
            chm_pkg::ST_NODE_CHK:
            begin
                if (cmp_res.key_eq)
                begin
                    state_next = chm_pkg::ST_IDLE;
                end
                else if (cmp_res.link_null)
                begin
                    state_next = (ins_reg && !pool_full) ? chm_pkg::ST_ALLOC
                                                         : chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_ALLOC:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls and results
    always_comb
    begin
        bkt_re      = 1'b0;
        bkt_raddr   = lookup_key[chm_pkg::BKT_W-1:0];
        bkt_we      = 1'b0;
        bkt_waddr   = key_idx;
        bkt_wdata   = '0;
        node_re     = 1'b0;
        node_raddr  = link_dec[chm_pkg::NODE_W-1:0];
        node_we     = 1'b0;
        node_waddr  = nodes_used_reg[chm_pkg::NODE_W-1:0];
        node_wdata  = '0;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        nodes_inc   = 1'b0;
        bkt_cap     = 1'b0;
        done_next   = 1'b0;
        hout_next   = '0;
        hit_next    = 1'b0;
        status_next = 1'b0;

        unique case (state_reg)
            chm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode) inside
                        chm_pkg::MODE_LOOKUP, chm_pkg::MODE_INSERT:
                        begin
                            bkt_re = 1'b1;
                        end
                        chm_pkg::MODE_CLEAR:
                        begin
                            // empty all buckets and release the pool at once
                            valid_clr = 1'b1;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            // undefined mode: no operation
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            chm_pkg::ST_BKT_CHK:
            begin
                bkt_cap = 1'b1;
                if (cmp_res.empty)
                begin
                    done_next = 1'b1;
                    if (ins_reg)
                    begin
                        // fill the empty slot, chain link left as it was
                        bkt_we    = 1'b1;
                        bkt_wdata = '{key: key_reg, handle: hin_reg, link: bkt_view.link};
                        valid_set = 1'b1;
                        hout_next = hin_reg;
                    end
                end
                else if (cmp_res.key_eq)
                begin
                    done_next = 1'b1;
                    hit_next  = 1'b1;
                    hout_next = bkt_view.handle;
                end
                else if (cmp_res.link_null)
                begin
                    if (!ins_reg || pool_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ins_reg;
                    end
                end
                else
                begin
                    node_re = 1'b1;
                end
            end
            chm_pkg::ST_NODE_CHK:
            begin
                if (cmp_res.key_eq)
                begin
                    done_next = 1'b1;
                    hit_next  = 1'b1;
                    hout_next = node_rdata.handle;
                end
                else if (cmp_res.link_null)
                begin
                    if (!ins_reg || pool_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ins_reg;
                    end
                end
                else
                begin
                    node_re = 1'b1;
                end
            end
            chm_pkg::ST_ALLOC:
            begin
                // new node goes right after the bucket slot
                node_we    = 1'b1;
                node_wdata = '{key: key_reg, handle: hin_reg, link: bkt_reg.link};
                bkt_we     = 1'b1;
                bkt_wdata  = '{key: bkt_reg.key, handle: bkt_reg.handle,
                               link: nodes_used_reg + chm_pkg::LINK_W'(1)};
                nodes_inc  = 1'b1;
                done_next  = 1'b1;
                hout_next  = hin_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chm_pkg::ST_IDLE;
            valid_reg      <= '0;
            nodes_used_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (valid_clr)
            begin
                valid_reg      <= '0;
                nodes_used_reg <= '0;
            end
            else
            begin
                if (valid_set)
                begin
                    valid_reg[key_idx] <= 1'b1;
                end
                if (nodes_inc)
                begin
                    nodes_used_reg <= nodes_used_reg + chm_pkg::LINK_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == chm_pkg::ST_IDLE && start)
        begin
            key_reg <= lookup_key;
            hin_reg <= handle_in;
            ins_reg <= (mode == chm_pkg::MODE_INSERT);
        end
        if (bkt_cap)
        begin
            bkt_reg <= bkt_view;
        end
        hout_reg   <= hout_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != chm_pkg::ST_IDLE);
    assign done       = done_reg;
    assign handle_out = hout_reg;
    assign hit        = hit_reg;
    assign status     = status_reg;

endmodule

[src/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/chm_cmp.sv]
// ----------------------------------------------------------------------------
// chm_cmp: shared entry compare unit
// key match, empty slot and end-of-chain tests on one table entry
// ----------------------------------------------------------------------------
module chm_cmp (
    input  chm_pkg::entry_t             entry,
    input  logic [chm_pkg::KEY_W-1:0]   key,
    output chm_pkg::cmp_res_t           res
);

    always_comb
    begin
        res.key_eq    = (entry.key == key);
        res.empty     = (entry.handle == '0);
        res.link_null = (entry.link == '0);
    end

endmodule

[src/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker: port-level checks of the chained hash map
// result strobe timing and result field consistency
// ----------------------------------------------------------------------------
module chm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [chm_pkg::MODE_W-1:0]  mode,
    input  logic                        done,
    input  logic [chm_pkg::HDL_W-1:0]   handle_out,
    input  logic                        hit,
    input  logic                        status
);

    // a result only follows a request or a walk in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a request in flight");

    // the block is free again when a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while showing a result");

    // a dropped insert reports no handle and no hit
    a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!hit && handle_out == '0))
        else $error("dropped insert with handle or hit");

    // a clear answers in the next cycle with all fields zero
    a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == chm_pkg::MODE_CLEAR) |=>
            (done && !busy && handle_out == '0 && !hit && !status))
        else $error("clear response wrong");

endmodule

bind chained_hash_map_insert_lookup chm_checker u_chm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .done       (done),
    .handle_out (handle_out),
    .hit        (hit),
    .status     (status)
);
